/* sv/tevc_pkg.sv */
// Shared constants, widths and types for the triangle edge vote check.
// Used by the channel interfaces, the register file and the top level.
// No dependencies.
`default_nettype none

package tevc_pkg;

    // Point limits and coordinate width.
    localparam int MAX_POINTS = 65536;
    localparam int COORD_BITS = 12;

    // Count width holds MAX_POINTS itself.
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    // Signed coordinate differences.
    localparam int DIFF_W = COORD_BITS + 1;

    // Numerator y1*dx + (x-x1)*dy, signed.
    localparam int NUM_W = 2 * DIFF_W;

    // Quotient magnitude bits that can still land near a point.
    localparam int QUO_W = COORD_BITS + 1;

    // Divider step counter.
    localparam int STEP_W = $clog2(QUO_W);

    // Signed prediction and window bounds.
    localparam int PRED_W = QUO_W + 2;

    // Near window and flat-line limit.
    localparam int NEAR_LIMIT = 10;
    localparam int FLAT_LIMIT = 2;

    // Register map.
    localparam int NUM_REGS = 6;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int ADDR_W   = IDX_W + 2;
    localparam int DATA_W   = 32;

    localparam logic [IDX_W-1:0] REG_AX = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_AY = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_BX = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_BY = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_CX = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_CY = IDX_W'(5);

    typedef logic [COORD_BITS-1:0] t_coord;

    // Candidate vertices as held in configuration.
    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord cx;
        t_coord cy;
    } t_vertices;

endpackage

`default_nettype wire

/* sv/tevc_ifs.sv */
// Valid/ready channel interfaces for edge points in and verdicts out.
// Depends on tevc_pkg.
`default_nettype none

interface tevc_pt_if;
    logic                valid;
    logic                ready;
    tevc_pkg::t_coord    point_x;
    tevc_pkg::t_coord    point_y;
    logic                last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

interface tevc_res_if;
    logic                          valid;
    logic                          ready;
    logic                          is_triangle;
    logic [tevc_pkg::CNT_W-1:0]    points_matched;
    logic [tevc_pkg::CNT_W-1:0]    points_total;

    modport source (output valid, output is_triangle, output points_matched,
                    output points_total, input ready);
    modport sink   (input valid, input is_triangle, input points_matched,
                    input points_total, output ready);
endinterface

`default_nettype wire

/* sv/tevc_regs.sv */
// APB-style configuration registers holding the three candidate vertices.
// Depends on tevc_pkg.
`default_nettype none

module tevc_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [tevc_pkg::ADDR_W-1:0]   paddr,
    input  wire [tevc_pkg::DATA_W-1:0]   pwdata,
    output logic [tevc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output tevc_pkg::t_vertices          o_vtx
);

    tevc_pkg::t_vertices          r_vtx;
    logic [tevc_pkg::IDX_W-1:0]   w_idx;
    logic                         w_wr;
    tevc_pkg::t_coord             w_wdata;
    tevc_pkg::t_coord             w_rdata;

    assign pready  = 1'b1;
    assign w_idx   = paddr[tevc_pkg::ADDR_W-1:2];
    assign w_wr    = psel && penable && pwrite && pready;
    assign w_wdata = pwdata[tevc_pkg::COORD_BITS-1:0];

    // Register writes complete in the access cycle; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                tevc_pkg::REG_AX: begin r_vtx.ax <= w_wdata; end
                tevc_pkg::REG_AY: begin r_vtx.ay <= w_wdata; end
                tevc_pkg::REG_BX: begin r_vtx.bx <= w_wdata; end
                tevc_pkg::REG_BY: begin r_vtx.by <= w_wdata; end
                tevc_pkg::REG_CX: begin r_vtx.cx <= w_wdata; end
                tevc_pkg::REG_CY: begin r_vtx.cy <= w_wdata; end
                default: begin end
            endcase
        end
    end

    // Read back the addressed register, zero beyond the map.
    always_comb begin
        unique case (w_idx)
            tevc_pkg::REG_AX: w_rdata = r_vtx.ax;
            tevc_pkg::REG_AY: w_rdata = r_vtx.ay;
            tevc_pkg::REG_BX: w_rdata = r_vtx.bx;
            tevc_pkg::REG_BY: w_rdata = r_vtx.by;
            tevc_pkg::REG_CX: w_rdata = r_vtx.cx;
            tevc_pkg::REG_CY: w_rdata = r_vtx.cy;
            default:          w_rdata = '0;
        endcase
    end

    assign prdata = tevc_pkg::DATA_W'(w_rdata);
    assign o_vtx  = r_vtx;

endmodule

`default_nettype wire

/* sv/triangle_edge_vote_check.sv */
// Each point is tested against the lines AB, AC and BC in turn; a line passes at most through
// the DIFF, MUL1, MUL2, SUM and ABS states, 13 divider steps and the CHK state.
// A new point is taken only in idle, after the previous point is done; the shared multiplier
// and the one-bit-per-cycle divider are reused for every line.
// A last point holds the block until the previous verdict is taken; its verdict is valid next.
// Synchronous active-low reset clears the vertices, counts, sequencer state and verdict valid.
// Depends on tevc_pkg, tevc_ifs and tevc_regs.
`default_nettype none

module triangle_edge_vote_check (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    tevc_pt_if.sink                      i_pt,
    tevc_res_if.source                   o_res,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [tevc_pkg::ADDR_W-1:0]   paddr,
    input  wire [tevc_pkg::DATA_W-1:0]   pwdata,
    output logic [tevc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int CB = tevc_pkg::COORD_BITS;
    localparam int DW = tevc_pkg::DIFF_W;
    localparam int NW = tevc_pkg::NUM_W;
    localparam int QW = tevc_pkg::QUO_W;
    localparam int SW = tevc_pkg::STEP_W;
    localparam int PW = tevc_pkg::PRED_W;
    localparam int CW = tevc_pkg::CNT_W;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIFF = 4'd1;
    localparam logic [3:0] ST_MUL1 = 4'd2;
    localparam logic [3:0] ST_MUL2 = 4'd3;
    localparam logic [3:0] ST_SUM  = 4'd4;
    localparam logic [3:0] ST_ABS  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_CHK  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    // Line codes.
    localparam logic [1:0] LINE_AB = 2'd0;
    localparam logic [1:0] LINE_AC = 2'd1;
    localparam logic [1:0] LINE_BC = 2'd2;

    localparam logic signed [DW-1:0] FLAT_POS = DW'(tevc_pkg::FLAT_LIMIT);
    localparam logic signed [DW-1:0] FLAT_NEG = -FLAT_POS;
    localparam logic signed [PW-1:0] NEAR     = PW'(tevc_pkg::NEAR_LIMIT);
    localparam logic [CW-1:0]        CNT_MAX  = CW'(tevc_pkg::MAX_POINTS);

    tevc_pkg::t_vertices w_vtx;

    // Configuration registers.
    tevc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_vtx   (w_vtx)
    );

    logic [3:0]              r_state;
    logic [1:0]              r_line;
    logic                    r_hit;
    logic                    r_last;
    tevc_pkg::t_coord        r_px;
    tevc_pkg::t_coord        r_py;
    tevc_pkg::t_coord        r_y1;
    logic signed [DW-1:0]    r_dx;
    logic signed [DW-1:0]    r_dy;
    logic signed [DW-1:0]    r_ex;
    logic signed [NW-1:0]    r_num;
    logic signed [NW-1:0]    r_prod;
    logic [NW-1:0]           r_rem;
    logic [NW-1:0]           r_dvs;
    logic [QW-1:0]           r_quo;
    logic                    r_qneg;
    logic [SW-1:0]           r_step;
    logic [CW-1:0]           r_mcnt;
    logic [CW-1:0]           r_tcnt;
    logic                    r_ovalid;
    logic                    r_otri;
    logic [CW-1:0]           r_om;
    logic [CW-1:0]           r_ot;

    logic                    w_in_xfer;
    logic                    w_out_xfer;
    tevc_pkg::t_coord        w_x1;
    tevc_pkg::t_coord        w_y1;
    tevc_pkg::t_coord        w_x2;
    tevc_pkg::t_coord        w_y2;
    logic signed [DW-1:0]    n_dx;
    logic signed [DW-1:0]    n_dy;
    logic signed [DW-1:0]    n_ex;
    logic                    w_flat;
    logic signed [DW-1:0]    w_ma;
    logic signed [DW-1:0]    w_mb;
    logic signed [NW-1:0]    w_prod;
    logic [NW-1:0]           w_nmag;
    logic [CB-1:0]           w_dmag;
    logic                    w_over;
    logic                    w_sub_ok;
    logic [NW-1:0]           w_sub;
    logic signed [PW-1:0]    w_qext;
    logic signed [PW-1:0]    w_pred;
    logic signed [PW-1:0]    w_pyext;
    logic                    w_near;
    logic                    w_line_done;
    logic [CW-1:0]           n_mcnt;
    logic [CW-1:0]           n_tcnt;
    logic [CW+2:0]           w_m5;
    logic [CW+2:0]           w_t4;
    logic                    w_out_free;

    assign w_in_xfer  = i_pt.valid && i_pt.ready;
    assign w_out_xfer = o_res.valid && o_res.ready;
    assign i_pt.ready = (r_state == ST_IDLE);

    // Endpoints of the line under test.
    always_comb begin
        unique case (r_line)
            LINE_AB: begin
                w_x1 = w_vtx.ax; w_y1 = w_vtx.ay; w_x2 = w_vtx.bx; w_y2 = w_vtx.by;
            end
            LINE_AC: begin
                w_x1 = w_vtx.ax; w_y1 = w_vtx.ay; w_x2 = w_vtx.cx; w_y2 = w_vtx.cy;
            end
            default: begin
                w_x1 = w_vtx.bx; w_y1 = w_vtx.by; w_x2 = w_vtx.cx; w_y2 = w_vtx.cy;
            end
        endcase
    end

    // Line differences and the flat-line shortcut.
    assign n_dx   = $signed({1'b0, w_x2}) - $signed({1'b0, w_x1});
    assign n_dy   = $signed({1'b0, w_y2}) - $signed({1'b0, w_y1});
    assign n_ex   = $signed({1'b0, r_px}) - $signed({1'b0, w_x1});
    assign w_flat = ((n_dx <= FLAT_POS) && (n_dx >= FLAT_NEG)) ||
                    ((n_dy <= FLAT_POS) && (n_dy >= FLAT_NEG));

    // Shared multiplier: y1*dx first, then (x-x1)*dy.
    assign w_ma   = (r_state == ST_MUL1) ? $signed({1'b0, r_y1}) : r_ex;
    assign w_mb   = (r_state == ST_MUL1) ? r_dx : r_dy;
    assign w_prod = w_ma * w_mb;

    // Magnitudes and the range guard: a quotient of more than QW bits is far off.
    assign w_nmag = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
    assign w_dmag = r_dx[DW-1] ? CB'(-r_dx) : CB'(r_dx);
    assign w_over = w_nmag >= (NW'(w_dmag) << QW);

    // Restoring divider step.
    assign w_sub_ok = r_rem >= r_dvs;
    assign w_sub    = r_rem - r_dvs;

    // Signed prediction against the near window around the point.
    assign w_qext  = $signed(PW'(r_quo));
    assign w_pred  = r_qneg ? -w_qext : w_qext;
    assign w_pyext = $signed(PW'(r_py));
    assign w_near  = (w_pred > (w_pyext - NEAR)) && (w_pred < (w_pyext + NEAR));

    assign w_line_done = (r_line == LINE_BC);

    // Saturating counts and the 80 percent vote.
    assign n_mcnt     = (r_hit && (r_mcnt < CNT_MAX)) ? r_mcnt + CW'(1) : r_mcnt;
    assign n_tcnt     = (r_tcnt < CNT_MAX) ? r_tcnt + CW'(1) : r_tcnt;
    assign w_m5       = ((CW+3)'(n_mcnt) << 2) + (CW+3)'(n_mcnt);
    assign w_t4       = (CW+3)'(n_tcnt) << 2;
    assign w_out_free = !r_ovalid || o_res.ready;

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_line  <= LINE_AB;
            r_hit   <= 1'b0;
            r_mcnt  <= '0;
            r_tcnt  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_px    <= i_pt.point_x;
                        r_py    <= i_pt.point_y;
                        r_last  <= i_pt.last_point;
                        r_line  <= LINE_AB;
                        r_hit   <= 1'b0;
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_dx <= n_dx;
                    r_dy <= n_dy;
                    r_ex <= n_ex;
                    r_y1 <= w_y1;
                    if (w_flat) begin
                        r_hit   <= 1'b1;
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_num   <= w_prod;
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_prod  <= w_prod;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_num   <= r_num + r_prod;
                    r_state <= ST_ABS;
                end
                ST_ABS: begin
                    r_rem  <= w_nmag;
                    r_dvs  <= NW'(w_dmag) << (QW - 1);
                    r_qneg <= r_num[NW-1] ^ r_dx[DW-1];
                    r_quo  <= '0;
                    r_step <= SW'(QW - 1);
                    if (!w_over) begin
                        r_state <= ST_DIV;
                    end else if (w_line_done) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_line  <= r_line + 2'd1;
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIV: begin
                    if (w_sub_ok) begin
                        r_rem <= w_sub;
                    end
                    r_quo  <= {r_quo[QW-2:0], w_sub_ok};
                    r_dvs  <= r_dvs >> 1;
                    r_step <= r_step - SW'(1);
                    if (r_step == '0) begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (w_near) begin
                        r_hit   <= 1'b1;
                        r_state <= ST_FIN;
                    end else if (w_line_done) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_line  <= r_line + 2'd1;
                        r_state <= ST_DIFF;
                    end
                end
                ST_FIN: begin
                    if (!r_last) begin
                        r_mcnt  <= n_mcnt;
                        r_tcnt  <= n_tcnt;
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_mcnt  <= '0;
                        r_tcnt  <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Verdict output register; a new verdict loads once the previous one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == ST_FIN) && r_last && w_out_free) begin
            r_ovalid <= 1'b1;
            r_otri   <= w_m5 > w_t4;
            r_om     <= n_mcnt;
            r_ot     <= n_tcnt;
        end else if (w_out_xfer) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.is_triangle    = r_otri;
    assign o_res.points_matched = r_om;
    assign o_res.points_total   = r_ot;

endmodule

`default_nettype wire
